/* sv/bb3x3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3x3_pkg
// Shared types, sizes and constants of the 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3x3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 13;
    localparam int IN_ROW_W    = HEIGHT_W + 1;
    localparam int OUT_ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 24;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    typedef logic [PIX_W-1:0] pixel_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Request bundle from the control logic to the line memories.
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        pixel_t           wr_upper;
        pixel_t           wr_middle;
    } mem_req_t;

    // Reciprocal of the doubled pixel count, ceil(2^18 / (2n)). Exact for all
    // dividends that a 3x3 sum of 8-bit values can produce.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/bb3x3_in_if.sv */
// ----------------------------------------------------------------------------
// bb3x3_in_if
// Input channel: one pixel or flush word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3x3_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, req_type, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

/* sv/bb3x3_out_if.sv */
// ----------------------------------------------------------------------------
// bb3x3_out_if
// Output channel: one blurred pixel word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3x3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

/* sv/bb3x3_line_mem.sv */
// ----------------------------------------------------------------------------
// bb3x3_line_mem
// The two line stores, one column entry per row, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3x3_line_mem
    import bb3x3_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output pixel_t        rd_upper,
    output pixel_t        rd_middle
);

    pixel_t upper_mem  [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            upper_mem[req.wr_addr]  <= req.wr_upper;
            middle_mem[req.wr_addr] <= req.wr_middle;
        end
        if (req.rd_en)
        begin
            rd_upper  <= upper_mem[req.rd_addr];
            rd_middle <= middle_mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/box_blur_3x3_edge_clipped_unit.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_unit
// 3x3 box blur over an RGB raster stream, neighbors outside the image left out.
// ----------------------------------------------------------------------------
// A word that yields a result passes SHIFT, SUM and DIV into the output
// register; DIV holds while it is full and not taken. A new word is taken
// only in IDLE, once the last is through. The line-memory read, the window
// sum and the reciprocal multiply are each registered. Reset clears counters,
// window and the output valid flag; the line memories hold undefined data,
// which only ever lands in window places that are masked.
`default_nettype none

module box_blur_3x3_edge_clipped_unit
    import bb3x3_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bb3x3_in_if.sink                   pixel,
    bb3x3_out_if.source                result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The sequencer walks each word through up to four steps. IDLE takes the word
    // and starts the line-memory read at the input column. SHIFT receives the
    // two stored rows, shifts the window and writes the column back. SUM adds
    // the in-image window places and counts them. DIV multiplies by the
    // reciprocal of the doubled count to form the rounded-half-up mean.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM,
        ST_DIV
    } state_t;

    state_t               state_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [COL_W-1:0]     in_col_reg;
    logic [IN_ROW_W-1:0]  in_row_reg;
    logic [COL_W-1:0]     out_col_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    pixel_t               win_reg [3][3];
    pixel_t               pix_reg;
    logic [SUM_W-1:0]     sum_reg [3];
    logic [CNT_W-1:0]     cnt_reg;
    logic                 last_reg;

    logic                 out_valid_reg;
    logic [7:0]           red_reg;
    logic [7:0]           green_reg;
    logic [7:0]           blue_reg;
    logic                 frame_end_reg;

    mem_req_t mem_req;
    pixel_t   rd_upper;
    pixel_t   rd_middle;

    bb3x3_line_mem u_line_mem (
        .clk       (clk),
        .req       (mem_req),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    logic accept;
    logic pixels_due;
    logic out_free;

    assign pixel.ready = (state_reg == ST_IDLE);
    assign accept      = pixel.valid && pixel.ready;
    assign pixels_due  = (in_row_reg < {1'b0, height_reg});
    assign out_free    = !out_valid_reg || result.ready;

    assign result.valid     = out_valid_reg;
    assign result.red_out   = red_reg;
    assign result.green_out = green_reg;
    assign result.blue_out  = blue_reg;
    assign result.frame_end = frame_end_reg;

    // The read of the next column is issued on acceptance; the write-back of
    // the same column follows in SHIFT, so a later read always sees it.
    always_comb
    begin
        mem_req.rd_en     = accept && !(pixel.req_type && pixels_due);
        mem_req.rd_addr   = in_col_reg;
        mem_req.wr_en     = (state_reg == ST_SHIFT);
        mem_req.wr_addr   = in_col_reg;
        mem_req.wr_upper  = rd_middle;
        mem_req.wr_middle = pix_reg;
    end

    // Window edge masks for the result's center position.
    logic edge_top;
    logic edge_bottom;
    logic edge_left;
    logic edge_right;
    logic primed;

    assign edge_top    = (out_row_reg != '0);
    assign edge_bottom = ({1'b0, out_row_reg} + 1'b1) < height_reg;
    assign edge_left   = (out_col_reg != '0);
    assign edge_right  = ({1'b0, out_col_reg} + 1'b1) < width_reg;
    assign primed      = (in_row_reg >= IN_ROW_W'(2)) ||
                         ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg != '0));

    // Masked window sums, one per channel, and the neighbor count.
    logic [SUM_W-1:0] sum_next [3];
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        logic use_pos;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = '0;
        end
        cnt_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                use_pos = !((r == 0 && !edge_top) || (r == 2 && !edge_bottom) ||
                            (c == 0 && !edge_left) || (c == 2 && !edge_right));
                if (use_pos)
                begin
                    cnt_next = cnt_next + 1'b1;
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        sum_next[ch] = sum_next[ch] +
                                       SUM_W'(win_reg[r][c][(2 - ch) * 8 +: 8]);
                    end
                end
            end
        end
    end

    // Mean = (2*sum + n) / (2*n), done as a multiply by a table reciprocal.
    logic [7:0] mean_next [3];

    always_comb
    begin
        logic [SUM_W:0]             dividend;
        logic [SUM_W+RECIP_W:0]     product;
        for (int ch = 0; ch < 3; ch++)
        begin
            dividend = {sum_reg[ch], 1'b0} + (SUM_W+1)'(cnt_reg);
            product  = (SUM_W+RECIP_W+1)'(dividend) *
                       (SUM_W+RECIP_W+1)'(recip(cnt_reg));
            mean_next[ch] = product[RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_W'(MAX_WIDTH);
            height_reg    <= HEIGHT_W'(768);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            // In DIV the output register is reloaded instead of cleared.
            if (out_valid_reg && result.ready && (state_reg != ST_DIV))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    // A flush while pixels are still due is dropped at once.
                    if (accept && !(pixel.req_type && pixels_due))
                    begin
                        if (!pixel.req_type && pixels_due)
                        begin
                            pix_reg <= {pixel.red_in, pixel.green_in, pixel.blue_in};
                        end
                        else
                        begin
                            pix_reg <= '0;
                        end
                        state_reg <= ST_SHIFT;
                    end
                end

                ST_SHIFT:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= rd_upper;
                    win_reg[1][2] <= rd_middle;
                    win_reg[2][2] <= pix_reg;

                    if (({1'b0, in_col_reg} + 1'b1) >= width_reg)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 1'b1;
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end

                    state_reg <= primed ? ST_SUM : ST_IDLE;
                end

                ST_SUM:
                begin
                    sum_reg  <= sum_next;
                    cnt_reg  <= cnt_next;
                    last_reg <= !edge_bottom && !edge_right;
                    if (!edge_bottom && !edge_right)
                    begin
                        // Final pixel of the image: start over with the same size.
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    else if (!edge_right)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (out_free)
                    begin
                        red_reg       <= mean_next[0];
                        green_reg     <= mean_next[1];
                        blue_reg      <= mean_next[2];
                        frame_end_reg <= last_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // A size write aborts the current image.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        if (cfg_data[WIDTH_W-1:0] == '0)
                        begin
                            width_reg <= WIDTH_W'(1);
                        end
                        else if (cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH))
                        begin
                            width_reg <= WIDTH_W'(MAX_WIDTH);
                        end
                        else
                        begin
                            width_reg <= cfg_data[WIDTH_W-1:0];
                        end
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        if (cfg_data[HEIGHT_W-1:0] == '0)
                        begin
                            height_reg <= HEIGHT_W'(1);
                        end
                        else if (cfg_data[HEIGHT_W-1:0] > HEIGHT_W'(MAX_HEIGHT))
                        begin
                            height_reg <= HEIGHT_W'(MAX_HEIGHT);
                        end
                        else
                        begin
                            height_reg <= cfg_data[HEIGHT_W-1:0];
                        end
                    end
                    default:
                    begin
                        width_reg <= width_reg;
                    end
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire
